// ===== rtl/circle_circle_contact_assert.svh =====
// Assertion macros used by the circle contact top level.
`ifndef CIRCLE_CIRCLE_CONTACT_ASSERT_SVH
`define CIRCLE_CIRCLE_CONTACT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define CCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ccc_pkg.sv =====
// Types and constants of the circle contact block.
`default_nettype none
package ccc_pkg;
	localparam int POS_W   = 24;
	localparam int RADI_W  = 20;
	localparam int RSUM_W  = 21;
	localparam int DIFF_W  = 25;
	localparam int SQ_W    = 50;
	localparam int DSQ_W   = 51;
	localparam int RSQ_W   = 42;
	localparam int ROOT_W  = 29;
	localparam int RAD_W   = 2 * ROOT_W;
	localparam int NUM_W   = 49;
	localparam int DEN_W   = ROOT_W + 1;
	localparam int QUO_W   = 16;
	localparam int NRM_W   = 16;
	localparam int MAG_W   = 15;
	localparam int PROD_W  = MAG_W + RADI_W;
	localparam int ONE_Q14 = 16384;
	localparam int POS_MAX = 8388607;
	localparam int POS_MIN = -8388608;

	typedef struct packed {
		logic signed [POS_W-1:0] a_x;
		logic signed [POS_W-1:0] a_y;
		logic signed [POS_W-1:0] b_x;
		logic signed [POS_W-1:0] b_y;
		logic [RADI_W-1:0]       radius_a;
		logic [RADI_W-1:0]       radius_b;
	} ccc_pair_t;

	typedef struct packed {
		logic                    hit;
		logic [RSUM_W-1:0]       penetration;
		logic signed [NRM_W-1:0] normal_x;
		logic signed [NRM_W-1:0] normal_y;
		logic signed [POS_W-1:0] contact_x;
		logic signed [POS_W-1:0] contact_y;
	} ccc_contact_t;

	// Per-item values that ride alongside the root and divider pipelines.
	typedef struct packed {
		logic signed [POS_W-1:0] ax;
		logic signed [POS_W-1:0] ay;
		logic [RADI_W-1:0]       ra;
		logic [RSUM_W-1:0]       rsum;
		logic                    neg_x;
		logic                    neg_y;
		logic [DIFF_W-1:0]       mx;
		logic [DIFF_W-1:0]       my;
		logic                    hit;
		logic                    zero;
		logic [RSUM_W-1:0]       pen;
	} ccc_side_t;
endpackage
`default_nettype wire

// ===== rtl/ccc_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module ccc_isqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        vld_i,
	input  wire logic [ccc_pkg::RAD_W-1:0]   rad_i,
	output logic                             vld_o,
	output logic [ccc_pkg::ROOT_W-1:0]       root_o
);
	localparam int N  = ccc_pkg::ROOT_W;
	localparam int RW = ccc_pkg::RAD_W;

	logic [N:0]    vld_s;
	logic [RW-1:0] rad_s  [0:N];
	logic [N+2:0]  rem_s  [0:N];
	logic [N-1:0]  root_s [0:N];

	assign vld_s[0]  = vld_i;
	assign rad_s[0]  = rad_i;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [N+2:0] rem_sh;
		logic [N+2:0] trial;
		logic         ge;

		assign rem_sh = {rem_s[k][N:0], rad_s[k][RW-1-2*k -: 2]};
		assign trial  = {1'b0, root_s[k], 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= rad_s[k];
				rem_s[k+1]  <= ge ? rem_sh - trial : rem_sh;
				root_s[k+1] <= {root_s[k][N-2:0], ge};
			end
		end
	end

	assign vld_o  = vld_s[N];
	assign root_o = root_s[N];
endmodule
`default_nettype wire

// ===== rtl/ccc_qdiv.sv =====
// Pipelined restoring divider for the normal components, one quotient bit per stage.
`default_nettype none
module ccc_qdiv (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        vld_i,
	input  wire logic [ccc_pkg::NUM_W-1:0]   num_i,
	input  wire logic [ccc_pkg::DEN_W-1:0]   den_i,
	output logic                             vld_o,
	output logic [ccc_pkg::QUO_W-1:0]        quo_o
);
	localparam int Q  = ccc_pkg::QUO_W;
	localparam int NW = ccc_pkg::NUM_W;
	localparam int DW = ccc_pkg::DEN_W;

	logic [Q:0]    vld_s;
	logic [NW-1:0] num_s [0:Q];
	logic [DW-1:0] den_s [0:Q];
	logic [Q-1:0]  quo_s [0:Q];

	assign vld_s[0] = vld_i;
	assign num_s[0] = num_i;
	assign den_s[0] = den_i;
	assign quo_s[0] = '0;

	for (genvar k = 0; k < Q; k++) begin : g_stage
		logic [NW-1:0] sh;
		logic          ge;

		assign sh = NW'(den_s[k]) << (Q - 1 - k);
		assign ge = num_s[k] >= sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k+1] <= ge ? num_s[k] - sh : num_s[k];
				den_s[k+1] <= den_s[k];
				quo_s[k+1] <= {quo_s[k][Q-2:0], ge};
			end
		end
	end

	assign vld_o = vld_s[Q];
	assign quo_o = quo_s[Q];
endmodule
`default_nettype wire

// ===== rtl/circle_circle_contact.sv =====
// Top level of the circle-circle contact pipeline.
// Usage:
// An item on the pair channel carries two circle centres (signed Q16.8) and
// two radii (unsigned Q12.8). It is taken at a rising edge where pair_valid
// is high and pair_stall is low. Exactly one item leaves on the contact
// channel for every pair taken, in order, taken where contact_valid is high
// and contact_stall is low. A pair that overlaps gives hit with penetration,
// a unit normal in Q2.14 and a contact point on A's rim; otherwise every
// field is zero.
// From acceptance to the output register, a pair passes through the
// difference, squaring and overlap-test stages, the bit-per-stage square
// root, the penetration stage, the bit-per-stage normal divider, the radius
// multiply and the contact point with saturation.
// Throughput is one pair per cycle while the receiver does not stall; the
// whole pipeline moves together.
// When the receiver stalls a waiting result, every stage holds and
// pair_stall rises in the same cycle, so nothing is dropped or repeated.
// Reset clears all valid bits; the pipeline starts empty.
`default_nettype none
`include "circle_circle_contact_assert.svh"
module circle_circle_contact (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   pair_valid,
	output logic                        pair_stall,
	input  wire ccc_pkg::ccc_pair_t     pair,
	output logic                        contact_valid,
	input  wire logic                   contact_stall,
	output ccc_pkg::ccc_contact_t       contact
);
	localparam int SQ_LAT  = ccc_pkg::ROOT_W;
	localparam int DIV_LAT = ccc_pkg::QUO_W;
	localparam int DW      = ccc_pkg::DIFF_W;

	// One enable for every stage: advance unless a finished result is held.
	logic adv;
	assign adv        = !(contact_valid && contact_stall);
	assign pair_stall = !adv;

	// Stage 1: centre differences and radius sum.
	logic                            v_s1;
	logic signed [ccc_pkg::POS_W-1:0] ax_s1, ay_s1;
	logic [ccc_pkg::RADI_W-1:0]      ra_s1;
	logic [ccc_pkg::RSUM_W-1:0]      r_s1;
	logic signed [DW-1:0]            dx_s1, dy_s1;

	// Stage 2: squares.
	logic                            v_s2;
	logic [ccc_pkg::SQ_W-1:0]        mx2_s2, my2_s2;
	logic [ccc_pkg::RSQ_W-1:0]       rsq_s2;
	ccc_pkg::ccc_side_t              side_s2;

	// Stage 3: overlap test and root operand.
	logic                            v_s3;
	logic [ccc_pkg::RAD_W-1:0]       rad_s3;
	ccc_pkg::ccc_side_t              side_s3;

	logic [DW-1:0] mx_c, my_c;
	assign mx_c = dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
	assign my_c = dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1);

	logic [ccc_pkg::DSQ_W-1:0] dsq_c;
	assign dsq_c = ccc_pkg::DSQ_W'(mx2_s2) + ccc_pkg::DSQ_W'(my2_s2);

	// Side values of stage 3 with the overlap and coincidence flags filled in.
	ccc_pkg::ccc_side_t side3_c;
	always_comb begin
		side3_c      = side_s2;
		side3_c.hit  = dsq_c < ccc_pkg::DSQ_W'(rsq_s2);
		side3_c.zero = dsq_c == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pair_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1 <= pair.a_x;
			ay_s1 <= pair.a_y;
			ra_s1 <= pair.radius_a;
			r_s1  <= ccc_pkg::RSUM_W'(pair.radius_a) + ccc_pkg::RSUM_W'(pair.radius_b);
			dx_s1 <= DW'(pair.b_x) - DW'(pair.a_x);
			dy_s1 <= DW'(pair.b_y) - DW'(pair.a_y);

			mx2_s2       <= mx_c * mx_c;
			my2_s2       <= my_c * my_c;
			rsq_s2       <= r_s1 * r_s1;
			side_s2.ax    <= ax_s1;
			side_s2.ay    <= ay_s1;
			side_s2.ra    <= ra_s1;
			side_s2.rsum  <= r_s1;
			side_s2.neg_x <= dx_s1[DW-1];
			side_s2.neg_y <= dy_s1[DW-1];
			side_s2.mx    <= mx_c;
			side_s2.my    <= my_c;
			side_s2.hit   <= 1'b0;
			side_s2.zero  <= 1'b0;
			side_s2.pen   <= '0;

			rad_s3       <= {dsq_c[ccc_pkg::RSQ_W-1:0], 16'b0};
			side_s3      <= side3_c;
		end
	end

	// Square root of the squared distance, Q.16 result.
	logic                        sq_vld;
	logic [ccc_pkg::ROOT_W-1:0]  root;

	ccc_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (v_s3),
		.rad_i  (rad_s3),
		.vld_o  (sq_vld),
		.root_o (root)
	);

	// Side values delayed to line up with the root.
	ccc_pkg::ccc_side_t sqd_s [0:SQ_LAT];
	assign sqd_s[0] = side_s3;
	for (genvar k = 0; k < SQ_LAT; k++) begin : g_sqd
		always_ff @(posedge clk) begin
			if (adv) begin
				sqd_s[k+1] <= sqd_s[k];
			end
		end
	end

	// Stage 4: penetration and divider operands.
	logic                        v_s4;
	ccc_pkg::ccc_side_t          side_s4;
	logic [ccc_pkg::NUM_W-1:0]   numx_s4, numy_s4;
	logic [ccc_pkg::DEN_W-1:0]   den_s4;

	ccc_pkg::ccc_side_t        sq_side;
	logic [21:0]               dq8_c;
	logic [ccc_pkg::RSUM_W-1:0] pen_c;
	assign sq_side = sqd_s[SQ_LAT];
	assign dq8_c   = 22'((30'(root) + 30'd128) >> 8);
	always_comb begin
		if (sq_side.zero) begin
			pen_c = ccc_pkg::RSUM_W'(sq_side.ra);
		end else if (dq8_c >= 22'(sq_side.rsum)) begin
			pen_c = '0;
		end else begin
			pen_c = sq_side.rsum - dq8_c[ccc_pkg::RSUM_W-1:0];
		end
	end

	ccc_pkg::ccc_side_t side4_c;
	always_comb begin
		side4_c     = sq_side;
		side4_c.pen = pen_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4     <= side4_c;
			numx_s4     <= {sq_side.mx[DW-2:0], 23'b0} + ccc_pkg::NUM_W'(root);
			numy_s4     <= {sq_side.my[DW-2:0], 23'b0} + ccc_pkg::NUM_W'(root);
			den_s4      <= {root, 1'b0};
		end
	end

	// Normal components: rounded |d| * 2^22 / s.
	logic                       dvx_vld, dvy_vld;
	logic [ccc_pkg::QUO_W-1:0]  qx, qy;

	ccc_qdiv u_qdiv_x (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (v_s4),
		.num_i  (numx_s4),
		.den_i  (den_s4),
		.vld_o  (dvx_vld),
		.quo_o  (qx)
	);

	ccc_qdiv u_qdiv_y (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (v_s4),
		.num_i  (numy_s4),
		.den_i  (den_s4),
		.vld_o  (dvy_vld),
		.quo_o  (qy)
	);

	ccc_pkg::ccc_side_t dvd_s [0:DIV_LAT];
	assign dvd_s[0] = side_s4;
	for (genvar k = 0; k < DIV_LAT; k++) begin : g_dvd
		always_ff @(posedge clk) begin
			if (adv) begin
				dvd_s[k+1] <= dvd_s[k];
			end
		end
	end

	// Stage 5: clamp, sign and radius multiply.
	logic                             v_s5;
	ccc_pkg::ccc_side_t               side_s5;
	logic signed [ccc_pkg::NRM_W-1:0] nx_s5, ny_s5;
	logic [ccc_pkg::PROD_W-1:0]       px_s5, py_s5;

	ccc_pkg::ccc_side_t         dv_side;
	logic [ccc_pkg::MAG_W-1:0]  magx_c, magy_c;
	assign dv_side = dvd_s[DIV_LAT];
	always_comb begin
		magx_c = (qx > ccc_pkg::QUO_W'(ccc_pkg::ONE_Q14)) ?
			ccc_pkg::MAG_W'(ccc_pkg::ONE_Q14) : qx[ccc_pkg::MAG_W-1:0];
		magy_c = (qy > ccc_pkg::QUO_W'(ccc_pkg::ONE_Q14)) ?
			ccc_pkg::MAG_W'(ccc_pkg::ONE_Q14) : qy[ccc_pkg::MAG_W-1:0];
		// Coincident centres point the normal along +x.
		if (dv_side.zero) begin
			magx_c = ccc_pkg::MAG_W'(ccc_pkg::ONE_Q14);
			magy_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= dvx_vld && dvy_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= dv_side;
			nx_s5   <= (dv_side.neg_x && !dv_side.zero) ?
				-ccc_pkg::NRM_W'(magx_c) : ccc_pkg::NRM_W'(magx_c);
			ny_s5   <= (dv_side.neg_y && !dv_side.zero) ?
				-ccc_pkg::NRM_W'(magy_c) : ccc_pkg::NRM_W'(magy_c);
			px_s5   <= magx_c * dv_side.ra;
			py_s5   <= magy_c * dv_side.ra;
		end
	end

	// Stage 6: contact point with saturation, then the output register.
	function automatic logic signed [ccc_pkg::POS_W-1:0] contact_comp(
		input logic signed [ccc_pkg::POS_W-1:0] a,
		input logic                             neg,
		input logic [ccc_pkg::PROD_W-1:0]       p
	);
		logic [21:0]        off;
		logic signed [25:0] c;
		off = 22'((36'(p) + 36'd8192) >> 14);
		c   = neg ? 26'(a) - 26'(off) : 26'(a) + 26'(off);
		if (c > 26'(ccc_pkg::POS_MAX)) begin
			return ccc_pkg::POS_W'(ccc_pkg::POS_MAX);
		end else if (c < 26'(ccc_pkg::POS_MIN)) begin
			return ccc_pkg::POS_W'(ccc_pkg::POS_MIN);
		end else begin
			return c[ccc_pkg::POS_W-1:0];
		end
	endfunction

	ccc_pkg::ccc_contact_t res_c;
	always_comb begin
		res_c = '0;
		if (side_s5.hit) begin
			res_c.hit         = 1'b1;
			res_c.penetration = side_s5.pen;
			res_c.normal_x    = nx_s5;
			res_c.normal_y    = ny_s5;
			if (side_s5.zero) begin
				res_c.contact_x = side_s5.ax;
				res_c.contact_y = side_s5.ay;
			end else begin
				res_c.contact_x = contact_comp(side_s5.ax, nx_s5[ccc_pkg::NRM_W-1], px_s5);
				res_c.contact_y = contact_comp(side_s5.ay, ny_s5[ccc_pkg::NRM_W-1], py_s5);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			contact_valid <= 1'b0;
		end else if (adv) begin
			contact_valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			contact <= res_c;
		end
	end

	`CCC_ASSERT_NOW(a_miss_zero, contact_valid && !contact.hit,
		contact.penetration == '0 && contact.normal_x == '0 && contact.normal_y == '0 &&
		contact.contact_x == '0 && contact.contact_y == '0, "miss with nonzero fields")
	`CCC_ASSERT_NOW(a_normal_range, contact_valid && contact.hit,
		contact.normal_x <= 16'sd16384 && contact.normal_x >= -16'sd16384 &&
		contact.normal_y <= 16'sd16384 && contact.normal_y >= -16'sd16384,
		"normal out of unit range")
	`CCC_ASSERT_NOW(a_div_align, v_s4 || sq_vld || dvx_vld || dvy_vld, dvx_vld == dvy_vld,
		"normal dividers out of step")
	`CCC_ASSERT_NEXT(a_last_stage, adv && v_s5, contact_valid, "final stage item lost")
endmodule
`default_nettype wire

// ===== dv/circle_circle_contact_test.sv =====
// Testbench for the circle contact pipeline: directed and random pairs against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module circle_circle_contact_test;
	localparam int LATENCY = 51;
	localparam int LIMIT_CYCLES = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pair_valid = 1'b0;
	logic pair_stall;
	ccc_pkg::ccc_pair_t pair = '0;
	logic contact_valid;
	logic contact_stall = 1'b0;
	ccc_pkg::ccc_contact_t contact;

	circle_circle_contact uut (
		.clk(clk), .arst_n(arst_n),
		.pair_valid(pair_valid), .pair_stall(pair_stall), .pair(pair),
		.contact_valid(contact_valid), .contact_stall(contact_stall), .contact(contact)
	);

	always #5 clk = ~clk;

	// Pairs waiting to be offered, and contacts the block still owes us.
	ccc_pkg::ccc_pair_t pending_pairs[$];
	ccc_pkg::ccc_contact_t owed_contacts[$];
	int errors = 0;
	int hits_seen = 0;
	int misses_seen = 0;
	int cycles = 0;
	bit stimulus_done = 1'b0;
	bit sender_idle_ok = 1'b1;   // cleared while the sender holds off for a drain
	bit calm_phase = 1'b0;       // no idling on either side near the end
	int hold_off_request = 0;    // long receiver hold-off, counted down by the receiver
	bit pair_waiting = 1'b0;     // the offered item was not taken at the last rising edge

	// Appends one pair to the queue of items still to be offered.
	function automatic void queue_pair(ccc_pkg::ccc_pair_t p);
		pending_pairs = {pending_pairs, p};
	endfunction

	// Integer square root by the classic bit-pair method.
	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// One normal component: |d| / s in Q2.14, rounded half away, clamped to one.
	function automatic longint signed normal_part(longint signed d, longint unsigned s);
		longint unsigned m, q;
		m = (d < 0) ? longint'(-d) : longint'(d);
		q = ((m << 23) + s) / (2 * s);
		if (q > ccc_pkg::ONE_Q14) q = ccc_pkg::ONE_Q14;
		return (d < 0) ? -longint'(q) : longint'(q);
	endfunction

	// One contact component: centre plus normal times radius, saturated to Q16.8.
	function automatic longint signed rim_part(longint signed a, longint signed n,
			longint unsigned ra);
		longint unsigned p;
		longint signed off, c;
		p = ((n < 0) ? longint'(-n) : longint'(n)) * ra;
		off = longint'((p + 8192) >> 14);
		c = a + ((n < 0) ? -off : off);
		if (c > ccc_pkg::POS_MAX) c = ccc_pkg::POS_MAX;
		if (c < ccc_pkg::POS_MIN) c = ccc_pkg::POS_MIN;
		return c;
	endfunction

	function automatic ccc_pkg::ccc_contact_t predict_contact(ccc_pkg::ccc_pair_t p);
		ccc_pkg::ccc_contact_t r;
		longint signed ax, ay, dx, dy, nx, ny;
		longint unsigned ra, rsum, dsq, s, dq8;
		ax = p.a_x;
		ay = p.a_y;
		dx = longint'(p.b_x) - ax;
		dy = longint'(p.b_y) - ay;
		ra = p.radius_a;
		rsum = ra + p.radius_b;
		dsq = longint'(dx * dx) + longint'(dy * dy);
		r = '0;
		if (dsq >= rsum * rsum) return r;
		r.hit = 1'b1;
		if (dsq == 0) begin
			// Coincident centres: normal defaults to +x and contact sits at A.
			r.penetration = ccc_pkg::RSUM_W'(ra);
			r.normal_x = ccc_pkg::NRM_W'(ccc_pkg::ONE_Q14);
			r.normal_y = '0;
			r.contact_x = p.a_x;
			r.contact_y = p.a_y;
		end else begin
			s = int_sqrt(dsq << 16);
			dq8 = (s + 128) >> 8;
			r.penetration = (dq8 >= rsum) ? '0 : ccc_pkg::RSUM_W'(rsum - dq8);
			nx = normal_part(dx, s);
			ny = normal_part(dy, s);
			r.normal_x = ccc_pkg::NRM_W'(nx);
			r.normal_y = ccc_pkg::NRM_W'(ny);
			r.contact_x = ccc_pkg::POS_W'(rim_part(ax, nx, ra));
			r.contact_y = ccc_pkg::POS_W'(rim_part(ay, ny, ra));
		end
		return r;
	endfunction

	function automatic logic [ccc_pkg::POS_W-1:0] rand_pos();
		return ccc_pkg::POS_W'($urandom);
	endfunction

	// Random pair that mostly overlaps: B near A, radii scaled to the distance.
	function automatic ccc_pkg::ccc_pair_t rand_pair();
		ccc_pkg::ccc_pair_t p;
		int unsigned kind, span;
		kind = $urandom_range(0, 9);
		p.a_x = rand_pos();
		p.a_y = rand_pos();
		p.radius_a = ccc_pkg::RADI_W'($urandom);
		p.radius_b = ccc_pkg::RADI_W'($urandom);
		if (kind < 6) begin
			span = 1 << $urandom_range(1, 21);
			p.b_x = p.a_x + ccc_pkg::POS_W'($urandom_range(0, span) - span / 2);
			p.b_y = p.a_y + ccc_pkg::POS_W'($urandom_range(0, span) - span / 2);
			p.radius_a = ccc_pkg::RADI_W'($urandom_range(0, span));
			p.radius_b = ccc_pkg::RADI_W'($urandom_range(0, span));
		end else if (kind < 8) begin
			p.b_x = rand_pos();
			p.b_y = rand_pos();
		end else begin
			// Same centre or on an axis, to hit the exact corners.
			p.b_x = p.a_x + ccc_pkg::POS_W'($urandom_range(0, 3) == 0 ? 0 :
				$urandom_range(0, 4095));
			p.b_y = p.a_y;
		end
		return p;
	endfunction

	function automatic ccc_pkg::ccc_pair_t make_pair(int ax, int ay, int bx, int by,
			int ra, int rb);
		ccc_pkg::ccc_pair_t p;
		p.a_x = ccc_pkg::POS_W'(ax);
		p.a_y = ccc_pkg::POS_W'(ay);
		p.b_x = ccc_pkg::POS_W'(bx);
		p.b_y = ccc_pkg::POS_W'(by);
		p.radius_a = ccc_pkg::RADI_W'(ra);
		p.radius_b = ccc_pkg::RADI_W'(rb);
		return p;
	endfunction

	// Driver: offers the queue head at the falling edge, with random idle bursts.
	int sender_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!pair_waiting) begin
				if (sender_gap > 0) begin
					sender_gap <= sender_gap - 1;
					pair_valid <= 1'b0;
				end else if (!calm_phase && $urandom_range(0, 15) == 0) begin
					sender_gap <= $urandom_range(1, 19) - 1;
					pair_valid <= 1'b0;
				end else if (sender_idle_ok && pending_pairs.size() > 0) begin
					pair <= pending_pairs.pop_front();
					pair_valid <= 1'b1;
				end else begin
					pair_valid <= 1'b0;
				end
			end
		end
	end

	// Predictions are made at acceptance so their order matches the block.
	always @(posedge clk) begin
		if (arst_n) begin
			pair_waiting <= pair_valid && pair_stall;
			if (pair_valid && !pair_stall) begin
				owed_contacts = {owed_contacts, predict_contact(pair)};
			end
		end
	end

	// Receiver stall: random bursts, plus a long hold-off on request.
	int receiver_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_off_request > 0) begin
				hold_off_request <= hold_off_request - 1;
				contact_stall <= 1'b1;
			end else if (receiver_gap > 0) begin
				receiver_gap <= receiver_gap - 1;
				contact_stall <= 1'b1;
			end else if (!calm_phase && $urandom_range(0, 15) == 0) begin
				receiver_gap <= $urandom_range(1, 19) - 1;
				contact_stall <= 1'b1;
			end else begin
				contact_stall <= 1'b0;
			end
		end
	end

	// Monitor: every accepted contact is compared field by field with the oldest prediction.
	always @(posedge clk) begin
		ccc_pkg::ccc_contact_t want;
		if (arst_n && contact_valid && !contact_stall) begin
			if (owed_contacts.size() == 0) begin
				$display("%0t: unexpected contact %h", $realtime, contact);
				errors++;
			end else begin
				want = owed_contacts.pop_front();
				if (want.hit) hits_seen++;
				else misses_seen++;
				if (contact.hit !== want.hit)
					$display("%0t: hit expected %0d got %0d", $realtime, want.hit, contact.hit);
				if (contact.penetration !== want.penetration)
					$display("%0t: penetration expected %0d got %0d", $realtime,
						want.penetration, contact.penetration);
				if (contact.normal_x !== want.normal_x)
					$display("%0t: normal_x expected %0d got %0d", $realtime,
						want.normal_x, contact.normal_x);
				if (contact.normal_y !== want.normal_y)
					$display("%0t: normal_y expected %0d got %0d", $realtime,
						want.normal_y, contact.normal_y);
				if (contact.contact_x !== want.contact_x)
					$display("%0t: contact_x expected %0d got %0d", $realtime,
						want.contact_x, contact.contact_x);
				if (contact.contact_y !== want.contact_y)
					$display("%0t: contact_y expected %0d got %0d", $realtime,
						want.contact_y, contact.contact_y);
				if (contact !== want) errors++;
			end
		end
	end

	// Watchdog: ends a hung run with the failure message.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("circle_circle_contact_test: errors");
			$finish;
		end
	end

	initial begin
		int i;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed corners: zero radii, coincident centres, exact touching,
		// extreme coordinates and radii, saturation of the contact point and
		// near-touching pairs.
		queue_pair(make_pair(0, 0, 0, 0, 0, 0));
		queue_pair(make_pair(100, -200, 100, -200, 0, 0));
		queue_pair(make_pair(100, -200, 100, -200, 512, 0));
		queue_pair(make_pair(-8388608, 8388607, -8388608, 8388607, 1048575, 1048575));
		queue_pair(make_pair(0, 0, 768, 1024, 640, 640));
		queue_pair(make_pair(0, 0, 768, 1024, 640, 641));
		queue_pair(make_pair(0, 0, 1, 0, 1, 1));
		queue_pair(make_pair(0, 0, 0, -1, 0, 2));
		queue_pair(make_pair(8388607, 8388607, 8388000, 8388000, 1048575, 1048575));
		queue_pair(make_pair(8388000, 8388000, 8388607, 8388607, 1048575, 1048575));
		queue_pair(make_pair(-8388608, -8388608, -8388000, -8388000, 1048575, 1));
		queue_pair(make_pair(-8388000, -8388000, -8388608, -8388608, 1048575, 0));
		queue_pair(make_pair(-8388608, -8388608, 8388607, 8388607, 1048575, 1048575));
		queue_pair(make_pair(8388607, 0, -8388608, 0, 1048575, 1048575));
		queue_pair(make_pair(0, 0, 500000, 500000, 1048575, 1048575));
		queue_pair(make_pair(0, 0, -3, 4, 1048575, 0));
		queue_pair(make_pair(0, 0, 0, 256, 0, 255));
		queue_pair(make_pair(10, 10, 10, 11, 0, 1048575));
		queue_pair(make_pair(-1, -1, 0, 0, 1048575, 1048575));
		queue_pair(make_pair(0, 0, 1048575, 1048575, 1048575, 1048575));
		wait (pending_pairs.size() == 0);

		// Sender pauses until every owed contact has come back.
		sender_idle_ok = 1'b0;
		wait (owed_contacts.size() == 0);
		sender_idle_ok = 1'b1;

		// Receiver holds off long enough for the pipeline to fill and stall the input.
		for (i = 0; i < 200; i++) queue_pair(rand_pair());
		@(negedge clk);
		hold_off_request = 150;
		wait (pending_pairs.size() == 0);

		for (i = 0; i < 1300; i++) queue_pair(rand_pair());
		wait (pending_pairs.size() == 0);

		// Last stretch runs at full rate on both sides.
		calm_phase = 1'b1;
		for (i = 0; i < 200; i++) queue_pair(rand_pair());
		wait (pending_pairs.size() == 0);
		@(negedge clk);
		wait (!pair_valid || !pair_stall);
		@(posedge clk);
		wait (owed_contacts.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);

		$display("Checked %0d contacts (%0d overlapping, %0d apart) under random stalls.",
			hits_seen + misses_seen, hits_seen, misses_seen);
		if (errors == 0 && owed_contacts.size() == 0) begin
			$display("circle_circle_contact_test: clean");
		end else begin
			$display("circle_circle_contact_test: errors");
		end
		$finish;
	end
endmodule
`default_nettype wire
